// File: rtl/assert_macros.svh
// Assertion macros shared by the trace ring RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every clk edge, off while reset is low
`define VRTR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// trigger in one cycle, consequence in the next
`define VRTR_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`endif

// File: rtl/vrtr_pkg.sv
// Shared types and constants of the trace record ring
package vrtr_pkg;
	localparam int STORE_BYTES_DEF = 4096;
	localparam int PAYLOAD_MAX_DEF = 256;
	localparam int HDR_BYTES = 12;
	localparam int KIND_AT = 8;
	localparam int FLAGS_AT = 9;
	localparam int LEN_AT = 10;
	localparam int OFS_W = 13;
	localparam int LEN_W = 16;
	localparam int HELD_W = 10;
	localparam int CNT_W = 32;
	localparam int BUF_RESET = 4096;

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_BYTE   = 3'd1,
		OP_CLEAR  = 3'd2,
		OP_REWIND = 3'd3,
		OP_RDHDR  = 3'd4,
		OP_RDBYTE = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_REFUSED = 2'd1,
		STAT_IGNORED = 2'd2,
		STAT_NOREAD  = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		REG_BUF_BYTES = 2'd0,
		REG_KEEP_OLD  = 2'd1,
		REG_SUSPEND   = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FIT, S_EVB, S_EVC, S_WRITE, S_RHL, S_RBB, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_CAPTURE, CMD_IGNORE, CMD_NOREAD, CMD_REFUSE, CMD_GAP, CMD_REBASE,
		CMD_EVA, CMD_EVB, CMD_EVC, CMD_WRITE, CMD_BYTE, CMD_CLEAR, CMD_REWIND,
		CMD_RH_BASE, CMD_RH_STEP, CMD_RB_ISSUE, CMD_RB_TAKE, CMD_LOAD
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       susp;
		logic       too_long;
		logic       fits;
		logic       held_zero;
		logic       keep;
		logic       wr_last;
		logic       rh_last;
		logic       byte_ok;
		logic       cur_left_zero;
		logic       cur_pl_zero;
		logic       out_free;
	} dp_flags_t;
endpackage

// File: rtl/vrtr_if.sv
// Request, response and register write channels of the trace ring
interface vrtr_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [63:0] time_us;
	logic [7:0]  rec_kind;
	logic [15:0] payload_length;
	logic [7:0]  data_byte;
	modport source(output valid, opcode, time_us, rec_kind, payload_length, data_byte,
		input ready);
	modport sink(input valid, opcode, time_us, rec_kind, payload_length, data_byte,
		output ready);
endinterface

interface vrtr_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] read_time_us;
	logic [7:0]  read_kind;
	logic [7:0]  read_flags;
	logic [8:0]  read_length;
	logic [7:0]  read_byte;
	logic [8:0]  record_count;
	logic [12:0] used_bytes;
	logic [31:0] total_written;
	logic [31:0] total_evicted;
	logic [31:0] total_refused;
	modport source(output valid, status, read_time_us, read_kind, read_flags, read_length,
		read_byte, record_count, used_bytes, total_written, total_evicted, total_refused,
		input ready);
	modport sink(input valid, status, read_time_us, read_kind, read_flags, read_length,
		read_byte, record_count, used_bytes, total_written, total_evicted, total_refused,
		output ready);
endinterface

interface vrtr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/vrtr_ram.sv
// Generic single-write, single-read RAM with registered read data
module vrtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/vrtr_ctrl.sv
// Sequencer of the trace ring: decodes requests and steps the datapath
module vrtr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  vrtr_pkg::dp_flags_t   flags,
	output vrtr_pkg::cmd_t        cmd
);
	import vrtr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_d = S_DECODE;
			S_DECODE: begin
				unique case (flags.op)
					OP_APPEND: state_d = (flags.susp || flags.too_long) ? S_DONE : S_FIT;
					OP_RDHDR:  state_d = flags.cur_left_zero ? S_DONE : S_RHL;
					OP_RDBYTE: state_d = flags.cur_pl_zero ? S_DONE : S_RBB;
					default:   state_d = S_DONE;
				endcase
			end
			S_FIT: begin
				if (flags.fits)
					state_d = S_WRITE;
				else if (flags.held_zero)
					state_d = S_FIT;
				else if (flags.keep)
					state_d = S_DONE;
				else
					state_d = S_EVB;
			end
			S_EVB:   state_d = S_EVC;
			S_EVC:   state_d = S_FIT;
			S_WRITE: if (flags.wr_last) state_d = S_DONE;
			S_RHL:   if (flags.rh_last) state_d = S_DONE;
			S_RBB:   state_d = S_DONE;
			S_DONE:  if (flags.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = CMD_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) cmd = CMD_CAPTURE;
			end
			S_DECODE: begin
				unique case (flags.op)
					OP_APPEND: begin
						if (flags.susp)
							cmd = CMD_IGNORE;
						else if (flags.too_long)
							cmd = CMD_REFUSE;
					end
					OP_BYTE:   cmd = flags.byte_ok ? CMD_BYTE : CMD_IGNORE;
					OP_CLEAR:  cmd = CMD_CLEAR;
					OP_REWIND: cmd = CMD_REWIND;
					OP_RDHDR:  cmd = flags.cur_left_zero ? CMD_NOREAD : CMD_RH_BASE;
					OP_RDBYTE: cmd = flags.cur_pl_zero ? CMD_NOREAD : CMD_RB_ISSUE;
					default:   cmd = CMD_IGNORE;
				endcase
			end
			S_FIT: begin
				if (flags.fits)
					cmd = CMD_GAP;
				else if (flags.held_zero)
					cmd = CMD_REBASE;
				else if (flags.keep)
					cmd = CMD_REFUSE;
				else
					cmd = CMD_EVA;
			end
			S_EVB:   cmd = CMD_EVB;
			S_EVC:   cmd = CMD_EVC;
			S_WRITE: cmd = CMD_WRITE;
			S_RHL:   cmd = CMD_RH_STEP;
			S_RBB:   cmd = CMD_RB_TAKE;
			S_DONE:  if (flags.out_free) cmd = CMD_LOAD;
			default: cmd = CMD_NONE;
		endcase
	end
endmodule

// File: rtl/vrtr_dp.sv
// Datapath of the trace ring: pointers, counters, cursor and result register
module vrtr_dp #(
	parameter int STORE_BYTES = vrtr_pkg::STORE_BYTES_DEF,
	parameter int PAYLOAD_MAX = vrtr_pkg::PAYLOAD_MAX_DEF,
	parameter int AW = $clog2(STORE_BYTES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vrtr_pkg::cmd_t      cmd,
	output vrtr_pkg::dp_flags_t flags,
	input  logic [2:0]          opcode,
	input  logic [63:0]         time_us,
	input  logic [7:0]          rec_kind,
	input  logic [15:0]         payload_length,
	input  logic [7:0]          data_byte,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [12:0]         cfg_data,
	output logic                ram_we,
	output logic [AW-1:0]       ram_waddr,
	output logic [7:0]          ram_wdata,
	output logic [AW-1:0]       ram_raddr,
	input  logic [7:0]          ram_rdata,
	vrtr_rsp_if.source          rsp
);
	import vrtr_pkg::*;

	localparam logic [OFS_W-1:0] WRAP_RST =
		(BUF_RESET > STORE_BYTES) ? OFS_W'(STORE_BYTES) : OFS_W'(BUF_RESET);

	logic [OFS_W-1:0]  buf_q, head_q, tail_q, used_q, wrap_q, fill_q, cur_ofs_q, idx_q;
	logic              keep_q, susp_q, oob_s1, out_valid_q;
	logic [HELD_W-1:0] held_q, cur_left_q;
	logic [CNT_W-1:0]  wr_cnt_q, ev_cnt_q, rf_cnt_q;
	logic [LEN_W-1:0]  pend_q, cur_pl_q, len_q, rlen_q;
	logic [2:0]        op_q;
	logic [63:0]       time_q, rtime_q;
	logic [7:0]        kind_q, dbyte_q, rkind_q, rflags_q, rbyte_q, lo_q;
	logic [1:0]        st_q;

	logic [OFS_W-1:0] sz, free_b, gap, rh_sum, rh_base, used_ev, ev_gap, used_gap;
	logic [16:0]      rec, ev_rec;
	logic [17:0]      head_rec, tail_full;
	logic [13:0]      raddr_full, waddr_full;
	logic [7:0]       rdat, wr_byte;
	logic [2:0]       hj;
	logic             oob_d;

	always_comb begin
		sz = (32'(buf_q) > STORE_BYTES) ? OFS_W'(STORE_BYTES) : buf_q;
		rec = 17'(len_q) + 17'(HDR_BYTES);
		free_b = (sz > used_q) ? sz - used_q : '0;
		head_rec = 18'(head_q) + 18'(rec);
		gap = (head_rec > 18'(sz)) ? sz - head_q : '0;
		rdat = oob_s1 ? 8'd0 : ram_rdata;
		// eviction of the record at the tail
		ev_rec = 17'({rdat, lo_q}) + 17'(HDR_BYTES);
		tail_full = 18'(tail_q) + 18'(ev_rec);
		used_ev = (ev_rec > 17'(used_q)) ? '0 : used_q - OFS_W'(ev_rec);
		ev_gap = (sz > wrap_q) ? sz - wrap_q : '0;
		used_gap = (ev_gap > used_ev) ? '0 : used_ev - ev_gap;
		rh_sum = cur_ofs_q + cur_pl_q[OFS_W-1:0];
		rh_base = (rh_sum == wrap_q) ? '0 : rh_sum;
		hj = 3'(idx_q - 13'd1);
	end

	always_comb begin
		case (idx_q)
			13'(KIND_AT):    wr_byte = kind_q;
			13'(FLAGS_AT):   wr_byte = 8'd0;
			13'(LEN_AT):     wr_byte = len_q[7:0];
			13'(LEN_AT + 1): wr_byte = len_q[15:8];
			default:         wr_byte = (idx_q < 13'(KIND_AT)) ? time_q[{idx_q[2:0], 3'b000} +: 8]
				: 8'd0;
		endcase
	end

	always_comb begin
		case (cmd)
			CMD_EVA:      raddr_full = 14'(tail_q) + 14'(LEN_AT);
			CMD_EVB:      raddr_full = 14'(tail_q) + 14'(LEN_AT + 1);
			CMD_RH_STEP:  raddr_full = 14'(cur_ofs_q) + 14'(idx_q);
			CMD_RB_ISSUE: raddr_full = 14'(cur_ofs_q);
			default:      raddr_full = '0;
		endcase
		oob_d = 32'(raddr_full) >= STORE_BYTES;
		ram_raddr = AW'(raddr_full);
		waddr_full = (cmd == CMD_BYTE) ? 14'(fill_q) : 14'(head_q) + 14'(idx_q);
		ram_waddr = AW'(waddr_full);
		ram_wdata = (cmd == CMD_BYTE) ? dbyte_q : wr_byte;
		ram_we = (cmd == CMD_WRITE) || (cmd == CMD_BYTE && 32'(fill_q) < STORE_BYTES);
	end

	always_comb begin
		flags.op = op_q;
		flags.susp = susp_q;
		flags.too_long = (32'(len_q) > PAYLOAD_MAX) || (rec > 17'(sz));
		flags.fits = 18'(free_b) >= 18'(gap) + 18'(rec);
		flags.held_zero = held_q == '0;
		flags.keep = keep_q;
		flags.wr_last = idx_q == OFS_W'(rec - 17'd1);
		flags.rh_last = idx_q == OFS_W'(HDR_BYTES);
		flags.byte_ok = !susp_q && pend_q != '0;
		flags.cur_left_zero = cur_left_q == '0;
		flags.cur_pl_zero = cur_pl_q == '0;
		flags.out_free = !out_valid_q || rsp.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= OFS_W'(BUF_RESET);
			keep_q <= 1'b0;
			susp_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			used_q <= '0;
			wrap_q <= WRAP_RST;
			held_q <= '0;
			wr_cnt_q <= '0;
			ev_cnt_q <= '0;
			rf_cnt_q <= '0;
			pend_q <= '0;
			fill_q <= '0;
			cur_ofs_q <= '0;
			cur_left_q <= '0;
			cur_pl_q <= '0;
			idx_q <= '0;
			oob_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			oob_s1 <= oob_d;
			if (cmd == CMD_LOAD)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BUF_BYTES: begin
						buf_q <= cfg_data;
						wr_cnt_q <= '0;
						ev_cnt_q <= '0;
						rf_cnt_q <= '0;
						head_q <= '0;
						tail_q <= '0;
						used_q <= '0;
						held_q <= '0;
						wrap_q <= (32'(cfg_data) > STORE_BYTES) ? OFS_W'(STORE_BYTES) : cfg_data;
						pend_q <= '0;
						fill_q <= '0;
						cur_ofs_q <= '0;
						cur_left_q <= '0;
						cur_pl_q <= '0;
					end
					REG_KEEP_OLD: keep_q <= cfg_data[0];
					REG_SUSPEND:  susp_q <= cfg_data[0];
					default: ;
				endcase
			end else begin
				case (cmd)
					CMD_REFUSE: begin
						rf_cnt_q <= rf_cnt_q + 1'b1;
						pend_q <= '0;
					end
					CMD_GAP: begin
						if (gap != '0) begin
							wrap_q <= head_q;
							used_q <= used_q + gap;
							head_q <= '0;
						end
						idx_q <= '0;
					end
					CMD_REBASE: begin
						head_q <= '0;
						tail_q <= '0;
						used_q <= '0;
						wrap_q <= sz;
					end
					CMD_EVC: begin
						held_q <= held_q - 1'b1;
						ev_cnt_q <= ev_cnt_q + 1'b1;
						if (tail_full == 18'(wrap_q)) begin
							used_q <= used_gap;
							tail_q <= '0;
							wrap_q <= sz;
						end else begin
							used_q <= used_ev;
							tail_q <= OFS_W'(tail_full);
						end
					end
					CMD_WRITE: begin
						idx_q <= idx_q + 1'b1;
						if (flags.wr_last) begin
							fill_q <= head_q + OFS_W'(HDR_BYTES);
							pend_q <= len_q;
							head_q <= (head_rec == 18'(sz)) ? '0 : OFS_W'(head_rec);
							used_q <= used_q + OFS_W'(rec);
							held_q <= held_q + 1'b1;
							wr_cnt_q <= wr_cnt_q + 1'b1;
						end
					end
					CMD_BYTE: begin
						fill_q <= fill_q + 1'b1;
						pend_q <= pend_q - 1'b1;
					end
					CMD_CLEAR: begin
						head_q <= '0;
						tail_q <= '0;
						used_q <= '0;
						held_q <= '0;
						wrap_q <= sz;
						pend_q <= '0;
						fill_q <= '0;
						cur_ofs_q <= '0;
						cur_left_q <= '0;
						cur_pl_q <= '0;
					end
					CMD_REWIND: begin
						cur_ofs_q <= tail_q;
						cur_left_q <= held_q;
						cur_pl_q <= '0;
					end
					CMD_RH_BASE: begin
						cur_ofs_q <= rh_base;
						cur_pl_q <= '0;
						idx_q <= '0;
					end
					CMD_RH_STEP: begin
						idx_q <= idx_q + 1'b1;
						if (flags.rh_last) begin
							cur_ofs_q <= cur_ofs_q + OFS_W'(HDR_BYTES);
							cur_pl_q <= {rdat, lo_q};
							cur_left_q <= cur_left_q - 1'b1;
						end
					end
					CMD_RB_TAKE: begin
						cur_ofs_q <= cur_ofs_q + 1'b1;
						cur_pl_q <= cur_pl_q - 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// request capture, header/byte read results and the response register
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_CAPTURE: begin
				op_q <= opcode;
				time_q <= time_us;
				kind_q <= rec_kind;
				len_q <= payload_length;
				dbyte_q <= data_byte;
				st_q <= STAT_DONE;
				rtime_q <= '0;
				rkind_q <= '0;
				rflags_q <= '0;
				rlen_q <= '0;
				rbyte_q <= '0;
			end
			CMD_IGNORE: st_q <= STAT_IGNORED;
			CMD_NOREAD: st_q <= STAT_NOREAD;
			CMD_REFUSE: st_q <= STAT_REFUSED;
			CMD_EVB:    lo_q <= rdat;
			CMD_RH_STEP: begin
				if (idx_q != '0 && idx_q <= 13'(KIND_AT))
					rtime_q[{hj, 3'b000} +: 8] <= rdat;
				if (idx_q == 13'(KIND_AT + 1))
					rkind_q <= rdat;
				if (idx_q == 13'(FLAGS_AT + 1))
					rflags_q <= rdat;
				if (idx_q == 13'(LEN_AT + 1))
					lo_q <= rdat;
				if (flags.rh_last)
					rlen_q <= {rdat, lo_q};
			end
			CMD_RB_TAKE: rbyte_q <= rdat;
			CMD_LOAD: begin
				rsp.status <= st_q;
				rsp.read_time_us <= rtime_q;
				rsp.read_kind <= rkind_q;
				rsp.read_flags <= rflags_q;
				rsp.read_length <= rlen_q[8:0];
				rsp.read_byte <= rbyte_q;
				rsp.record_count <= held_q[8:0];
				rsp.used_bytes <= used_q;
				rsp.total_written <= wr_cnt_q;
				rsp.total_evicted <= ev_cnt_q;
				rsp.total_refused <= rf_cnt_q;
			end
			default: ;
		endcase
	end

	assign rsp.valid = out_valid_q;
endmodule

// File: rtl/variable_record_trace_ring.sv
// Usage: requests enter on req, one response per request leaves on rsp.
// Registers (ring size, keep-oldest, suspend) are written on cfg, index as
// listed; the user must write them only while no request is in flight, as
// the block itself does not enforce it. cfg is always ready.
// A request is taken when req.valid and req.ready are high; ready is high
// only while the sequencer is idle, so requests are handled one at a time.
// An append start may first evict records at the tail, or rebase the ring
// when it holds no record, then writes the header and zeroed payload space.
// The byte store has one write port and takes one byte a cycle.
// The response sits in an output register: a new request is taken while it
// waits, and a stalled rsp only holds the sequencer at its final step.
// Reset clears all pointers, counters and the cursor and returns the ring
// size to 4096; the byte store is not cleared and needs no clearing pass.
module variable_record_trace_ring #(
	parameter int STORE_BYTES = vrtr_pkg::STORE_BYTES_DEF,
	parameter int PAYLOAD_MAX = vrtr_pkg::PAYLOAD_MAX_DEF
) (
	input logic        clk,
	input logic        arst_n,
	vrtr_req_if.sink   req,
	vrtr_rsp_if.source rsp,
	vrtr_cfg_if.sink   cfg
);
	import vrtr_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);

	cmd_t           cmd;
	dp_flags_t      flags;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]     ram_wdata, ram_rdata;

	assign cfg.ready = 1'b1;

	vrtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	vrtr_dp #(
		.STORE_BYTES (STORE_BYTES),
		.PAYLOAD_MAX (PAYLOAD_MAX),
		.AW          (AW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.flags          (flags),
		.opcode         (req.opcode),
		.time_us        (req.time_us),
		.rec_kind       (req.rec_kind),
		.payload_length (req.payload_length),
		.data_byte      (req.data_byte),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.rsp            (rsp)
	);

	vrtr_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`include "assert_macros.svh"

	// the sequencer is busy in the cycle after it takes a request
	`VRTR_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
	// a response whose status is not done carries a zero read time and read byte
	`VRTR_ASSERT(a_read_fields_clean, !rsp.valid || rsp.status == STAT_DONE || (rsp.read_time_us == '0 && rsp.read_byte == '0), "read data on failed request")
endmodule
